### sv/gmad_pkg.sv
// Shared widths, codes and types of the grouped mean absolute deviation block.
`default_nettype none
package gmad_pkg;
    localparam int FREQ_W          = 16;
    localparam int VAL_W           = 24;
    localparam int CLW_W           = 23;
    localparam int TOT_W           = 22;
    localparam int SUM_W           = 48;
    localparam int ACC_W           = 64;
    localparam int STAT_W          = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int MAX_CLASSES_DEF = 64;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_TOTAL = 2'd1,
        ST_OVERFLOW   = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LOWER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_WIDTH       = 1'b1;
endpackage
`default_nettype wire

### sv/gmad_if.sv
// Valid/ready channel interfaces for input beats and result beats.
`default_nettype none
interface gmad_in_if import gmad_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] class_frequency;
    logic              last_class;

    modport source (output valid, output class_frequency, output last_class, input ready);
    modport sink   (input valid, input class_frequency, input last_class, output ready);
endinterface

interface gmad_out_if import gmad_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  mean_value;
    logic [VAL_W-1:0]  mad_value;
    logic [STAT_W-1:0] status;

    modport source (output valid, output mean_value, output mad_value, output status,
                    input ready);
    modport sink   (input valid, input mean_value, input mad_value, input status,
                    output ready);
endinterface
`default_nettype wire

### sv/gmad_ram.sv
// Frequency store: one write port, one read port with registered read data.
`default_nettype none
module gmad_ram import gmad_pkg::*; #(
    parameter int DEPTH = MAX_CLASSES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [FREQ_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [FREQ_W-1:0] rdata
);
    logic [FREQ_W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry a cycle
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/gmad_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 22-bit divisor.
`default_nettype none
module gmad_div import gmad_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [ACC_W-1:0] dividend,
    input  wire logic [TOT_W-1:0] divisor,
    output logic                  done,
    output logic      [ACC_W-1:0] quotient
);
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TOT_W-1:0] rem_reg;
    logic [TOT_W-1:0] dvs_reg;
    logic [ACC_W-1:0] quo_reg;
    logic [TOT_W:0]   rem_sh;
    logic [TOT_W:0]   diff;
    logic             ge;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_reg, quo_reg[ACC_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

### sv/grouped_mean_absolute_deviation.sv
// Top level: grouped mean absolute deviation over a stored class frequency table.
// Each beat carries one class frequency; classes are equal width, starting at the
// configured lower limit of the first class, and each mark is the class midpoint.
// A beat that is not the last takes the accept step plus the multiply, mark and
// accumulate steps through the shared mark datapath; a beat arriving with the store
// full is dropped. The last beat adds a check step, the bit-serial divider for the
// mean, a pass that streams the N stored frequencies back out of the memory through
// the deviation pipeline, the divider again for the deviation and the load of the
// result register. For a zero total the check step goes straight to the result load.
// The result register holds a finished beat while a new set loads.
`default_nettype none
module grouped_mean_absolute_deviation import gmad_pkg::*; #(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VAL_W-1:0]     cfg_data,
    gmad_in_if.sink                   in_ch,
    gmad_out_if.source                out_ch
);
    localparam int AW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNTW = $clog2(MAX_CLASSES + 1);
    localparam int PRW  = AW + CLW_W;
    localparam int MW   = AW + 25;
    localparam int FMW  = MW + FREQ_W + 1;
    localparam int EW   = (FMW > SUM_W) ? FMW : SUM_W;
    localparam int ADW  = MW + 1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LMUL   = 9'b000000010,
        S_LMARK  = 9'b000000100,
        S_LMAC   = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_DMEAN  = 9'b000100000,
        S_PASS   = 9'b001000000,
        S_DDEV   = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [VAL_W-1:0] fll_reg;
    logic        [CLW_W-1:0] cw_reg;

    logic [CNTW-1:0]         count_reg;
    logic [TOT_W-1:0]        total_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    overflow_reg;
    logic [FREQ_W-1:0]       f_reg;
    logic                    last_reg;

    logic [PRW-1:0]          prod_reg;
    logic signed [MW-1:0]    mark_reg;
    logic [CNTW-1:0]         pass_k_reg;
    logic                    va_reg, vb_reg, vc_reg;
    logic [FREQ_W-1:0]       fb_reg, fc_reg;
    logic [ADW-1:0]          ad_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [VAL_W-1:0] mean_reg;
    logic                    neg_reg;

    logic                    out_valid_reg;
    logic [VAL_W-1:0]        res_mean_reg, out_mean_reg;
    logic [VAL_W-1:0]        res_dev_reg, out_dev_reg;
    status_t                 res_stat_reg, out_stat_reg;

    logic                    in_fire, out_fire, out_free;
    logic [AW-1:0]           k_sel;
    logic signed [MW-1:0]    mark_comb;
    logic signed [FMW-1:0]   fm;
    logic signed [EW-1:0]    fm_ext;
    logic signed [ADW-1:0]   d;
    logic [ADW+FREQ_W-1:0]   adf;
    logic [SUM_W-1:0]        mag;
    logic                    issue;
    logic                    pass_done;
    logic                    div_start, div_done;
    logic [ACC_W-1:0]        div_dividend, div_q;
    logic [FREQ_W-1:0]       ram_rdata;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_valid_reg && out_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fll_reg <= '0;
            cw_reg  <= CLW_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIRST_LOWER_LIMIT: fll_reg <= cfg_data;
                REG_CLASS_WIDTH:       cw_reg  <= cfg_data[CLW_W-1:0];
                default:               ;
            endcase
        end
    end

    // Shared mark datapath
    assign k_sel     = (state_reg == S_LMUL) ? count_reg[AW-1:0] : pass_k_reg[AW-1:0];
    assign mark_comb = $signed({{(MW-VAL_W){fll_reg[VAL_W-1]}}, fll_reg})
                     + $signed({2'b00, prod_reg})
                     + $signed({{(MW-CLW_W+1){1'b0}}, cw_reg[CLW_W-1:1]});
    assign fm        = $signed({1'b0, f_reg}) * mark_reg;
    assign fm_ext    = EW'(fm);
    assign d         = $signed({mark_reg[MW-1], mark_reg})
                     - $signed({{(ADW-VAL_W){mean_reg[VAL_W-1]}}, mean_reg});
    assign adf       = ad_reg * fc_reg;
    assign mag       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign issue     = (state_reg == S_PASS) && (pass_k_reg < count_reg);
    assign pass_done = (state_reg == S_PASS) && !issue && !va_reg && !vb_reg && !vc_reg;

    assign div_start    = ((state_reg == S_CHECK) && (total_reg != '0)) || pass_done;
    assign div_dividend = (state_reg == S_CHECK) ? ACC_W'(mag) : acc_reg;

    gmad_ram #(.DEPTH(MAX_CLASSES), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (state_reg == S_LMUL),
        .waddr (count_reg[AW-1:0]),
        .wdata (f_reg),
        .raddr (pass_k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    gmad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (count_reg < CNTW'(MAX_CLASSES))
                        state_next = S_LMUL;
                    else if (in_ch.last_class)
                        state_next = S_CHECK;
                end
            end
            S_LMUL:   state_next = S_LMARK;
            S_LMARK:  state_next = S_LMAC;
            S_LMAC:   state_next = last_reg ? S_CHECK : S_IDLE;
            S_CHECK:  state_next = (total_reg == '0) ? S_FINISH : S_DMEAN;
            S_DMEAN:  state_next = div_done ? S_PASS : S_DMEAN;
            S_PASS:   state_next = pass_done ? S_DDEV : S_PASS;
            S_DDEV:   state_next = div_done ? S_FINISH : S_DDEV;
            S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            overflow_reg  <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            pass_k_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            va_reg    <= issue;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            if (in_fire && !(count_reg < CNTW'(MAX_CLASSES)))
                overflow_reg <= 1'b1;
            if (state_reg == S_LMAC)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= total_reg + TOT_W'(f_reg);
                sum_reg   <= sum_reg + fm_ext[SUM_W-1:0];
            end
            if ((state_reg == S_DMEAN) && div_done)
                pass_k_reg <= '0;
            else if (issue)
                pass_k_reg <= pass_k_reg + 1'b1;
            // Hand the result to the output register and drop the set
            if ((state_reg == S_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                total_reg     <= '0;
                sum_reg       <= '0;
                overflow_reg  <= 1'b0;
            end
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            f_reg    <= in_ch.class_frequency;
            last_reg <= in_ch.last_class;
        end
        if ((state_reg == S_LMUL) || issue)
            prod_reg <= k_sel * cw_reg;
        if ((state_reg == S_LMARK) || va_reg)
            mark_reg <= mark_comb;
        fb_reg <= ram_rdata;
        fc_reg <= fb_reg;
        ad_reg <= d[ADW-1] ? ADW'(-d) : ADW'(d);
        if (state_reg == S_CHECK)
        begin
            neg_reg      <= sum_reg[SUM_W-1];
            res_mean_reg <= '0;
            res_dev_reg  <= '0;
            res_stat_reg <= ST_ZERO_TOTAL;
        end
        // Saturate the mean and open the deviation pass
        if ((state_reg == S_DMEAN) && div_done)
        begin
            acc_reg <= '0;
            if (!neg_reg)
                mean_reg <= (div_q > ACC_W'(8388607)) ? 24'sh7FFFFF : $signed(div_q[VAL_W-1:0]);
            else
                mean_reg <= (div_q > ACC_W'(8388608)) ? 24'sh800000
                                                      : $signed(-div_q[VAL_W-1:0]);
        end
        else if (vc_reg)
            acc_reg <= acc_reg + ACC_W'(adf);
        if ((state_reg == S_DDEV) && div_done)
        begin
            res_mean_reg <= mean_reg;
            res_dev_reg  <= (div_q > ACC_W'(16777215)) ? 24'hFFFFFF : div_q[VAL_W-1:0];
            res_stat_reg <= overflow_reg ? ST_OVERFLOW : ST_OK;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_mean_reg <= res_mean_reg;
            out_dev_reg  <= res_dev_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mean_value = out_mean_reg;
    assign out_ch.mad_value  = out_dev_reg;
    assign out_ch.status     = out_stat_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_CLASSES))
        else $error("class count beyond capacity");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DMEAN || state_reg == S_DDEV))
        else $error("divider finished outside a divide step");

    a_last_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LMAC && last_reg) |=> state_reg == S_CHECK)
        else $error("last beat did not start the result");
endmodule
`default_nettype wire
